/* design/psf_pkg.sv */
// Shared types and constants for the shock flattening coefficient pipeline.
package psf_pkg;

  localparam int WORD_W    = 32;            // pressures, velocities, registers
  localparam int NUM_FIELD = 6;             // input fields per item
  localparam int IN_W      = WORD_W * NUM_FIELD;
  localparam int FT_W      = 17;            // Q1.16 result
  localparam int OUT_W     = 24;            // result padded to whole bytes
  localparam int FRAC_W    = 16;            // Q16.16 fraction bits
  localparam int QBITS     = 32;            // quotient magnitude bits
  localparam int NUM_W     = WORD_W + FRAC_W;  // dividend |dP1| << 16
  localparam int PROD_W    = 2 * WORD_W;
  localparam int DIFF_W    = WORD_W + 2;
  localparam int CFG_IDX_W = 2;

  localparam logic [CFG_IDX_W-1:0] CFG_OMEGA_ONE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_OMEGA_TWO = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SHOCK_EPS = 2'd2;

  localparam logic [WORD_W-1:0] OMEGA_ONE_RST = 32'd49152;
  localparam logic [WORD_W-1:0] OMEGA_TWO_RST = 32'd655360;
  localparam logic [WORD_W-1:0] SHOCK_EPS_RST = 32'd21627;

  localparam logic [WORD_W-1:0] RATIO_MAX = 32'h7FFF_FFFF;
  localparam logic [WORD_W-1:0] RATIO_MIN = 32'h8000_0000;
  localparam logic [WORD_W-1:0] RATIO_ONE = 32'h0001_0000;
  localparam logic [FT_W-1:0]   ONE_Q16   = 17'h1_0000;

  typedef struct packed {
    logic shock;     // jump large enough and flow converging
    logic neg;       // dP1 and dP2 differ in sign
    logic dp2_zero;  // flat outer pressures
    logic ovf;       // quotient magnitude needs more than QBITS bits
  } psf_side_t;

endpackage

/* design/psf_div.sv */
// Pipelined restoring divider, one quotient bit per stage, with sideband.
module psf_div (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [psf_pkg::NUM_W-1:0]    in_num,
  input  logic [psf_pkg::WORD_W-1:0]   in_den,
  input  psf_pkg::psf_side_t           in_side,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [psf_pkg::QBITS-1:0]    out_quo,
  output psf_pkg::psf_side_t           out_side
);
  import psf_pkg::*;

  localparam int CMP_W = WORD_W + QBITS;

  logic [QBITS-1:0]  v_r;
  logic [QBITS:0]    rdy;
  logic [NUM_W-1:0]  rem_r  [QBITS];
  logic [WORD_W-1:0] den_r  [QBITS];
  logic [QBITS-1:0]  quo_r  [QBITS];
  psf_side_t         side_r [QBITS];

  assign rdy[QBITS] = out_ready;

  for (genvar j = 0; j < QBITS; j++) begin : g_stg
    localparam int K = QBITS - 1 - j;
    logic              v_in;
    logic [NUM_W-1:0]  rem_in;
    logic [WORD_W-1:0] den_in;
    logic [QBITS-1:0]  quo_in;
    psf_side_t         side_in;
    logic [CMP_W-1:0]  trial;
    logic              take;
    logic [NUM_W-1:0]  rem_nxt;
    logic [QBITS-1:0]  quo_nxt;

    if (j == 0) begin : g_first
      assign v_in    = in_valid;
      assign rem_in  = in_num;
      assign den_in  = in_den;
      assign quo_in  = '0;
      assign side_in = in_side;
    end else begin : g_next
      assign v_in    = v_r[j-1];
      assign rem_in  = rem_r[j-1];
      assign den_in  = den_r[j-1];
      assign quo_in  = quo_r[j-1];
      assign side_in = side_r[j-1];
    end

    assign rdy[j] = !v_r[j] || rdy[j+1];

    always_comb begin
      trial   = CMP_W'(den_in) << K;
      take    = CMP_W'(rem_in) >= trial;
      rem_nxt = take ? (rem_in - trial[NUM_W-1:0]) : rem_in;
      quo_nxt = quo_in;
      quo_nxt[K] = take;
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[j] <= 1'b0;
      end else if (rdy[j]) begin
        v_r[j] <= v_in;
      end
    end

    always_ff @(posedge clk) begin
      if (rdy[j] && v_in) begin
        rem_r[j]  <= rem_nxt;
        den_r[j]  <= den_in;
        quo_r[j]  <= quo_nxt;
        side_r[j] <= side_in;
      end
    end
  end

  assign in_ready  = rdy[0];
  assign out_valid = v_r[QBITS-1];
  assign out_quo   = quo_r[QBITS-1];
  assign out_side  = side_r[QBITS-1];

endmodule

/* design/ppm_shock_flattening_coefficient.sv */
// Top level of the shock flattening coefficient pipeline.
//
// Input stream (in_*): one transfer per cell face, six 32-bit fields in
// in_tdata. Result stream (out_*): one ftilde per input, Q1.16 in
// out_tdata. Configuration (cfg_*): index 0 omega_one, 1 omega_two,
// 2 shock_epsilon; other indexes are ignored. cfg_ready is always high;
// write only while the pipeline is empty.
//
// Throughput: one item per cycle while out_tready holds high. Depth: 39
// register stages: 3 front stages (differences, threshold multiply, shock
// compare), 32 divider stages (one quotient bit each), 4 back stages
// (saturate, offset, scale multiply, clamp into out reg).
// The 32-stage ratio divider sets the latency.
//
// Every stage has its own valid bit and takes data when it is empty or
// its successor moves, so bubbles are squeezed out when out_tready is low
// and new items keep entering until the pipeline is full. Nothing is lost
// or repeated under stall. Synchronous active-low reset empties all
// stages and loads the default register values.
module ppm_shock_flattening_coefficient (
  input  logic                            clk,
  input  logic                            rst_n,
  // in_tdata, low bit up: press_minus2, press_minus1, press_plus1,
  // press_plus2, vel_minus1, vel_plus1 (32 bits each)
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [psf_pkg::IN_W-1:0]        in_tdata,
  // out_tdata, low bit up: ftilde (17 bits), zero fill
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [psf_pkg::OUT_W-1:0]       out_tdata,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [psf_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [psf_pkg::WORD_W-1:0]      cfg_data
);
  import psf_pkg::*;

  // ---------------- configuration registers ----------------
  logic [WORD_W-1:0] omega_one_r, omega_two_r, shock_eps_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      omega_one_r <= OMEGA_ONE_RST;
      omega_two_r <= OMEGA_TWO_RST;
      shock_eps_r <= SHOCK_EPS_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_OMEGA_ONE: omega_one_r <= cfg_data;
        CFG_OMEGA_TWO: omega_two_r <= cfg_data;
        CFG_SHOCK_EPS: shock_eps_r <= cfg_data;
        default: ;  // index outside the register list: dropped
      endcase
    end
  end

  // ---------------- handshake chain ----------------
  logic va_r, vb_r, vs_r, vc_r, vd_r, ve_r, vf_r;
  logic rdy_a, rdy_b, rdy_s, rdy_c, rdy_d, rdy_e, rdy_f;
  logic div_in_ready, div_out_valid;

  assign rdy_f = !vf_r || out_tready;
  assign rdy_e = !ve_r || rdy_f;
  assign rdy_d = !vd_r || rdy_e;
  assign rdy_c = !vc_r || rdy_d;
  assign rdy_s = !vs_r || div_in_ready;
  assign rdy_b = !vb_r || rdy_s;
  assign rdy_a = !va_r || rdy_b;
  assign in_tready = rdy_a;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r <= 1'b0;
      vb_r <= 1'b0;
      vs_r <= 1'b0;
      vc_r <= 1'b0;
      vd_r <= 1'b0;
      ve_r <= 1'b0;
      vf_r <= 1'b0;
    end else begin
      if (rdy_a) va_r <= in_tvalid;
      if (rdy_b) vb_r <= va_r;
      if (rdy_s) vs_r <= vb_r;
      if (rdy_c) vc_r <= div_out_valid;
      if (rdy_d) vd_r <= vc_r;
      if (rdy_e) ve_r <= vd_r;
      if (rdy_f) vf_r <= ve_r;
    end
  end

  // ---------------- stage A: pressure differences ----------------
  logic [WORD_W-1:0] pm2, pm1, pp1, pp2, vm1, vp1;
  logic              dp1_neg, dp2_neg;
  logic [WORD_W-1:0] adp1_nxt, adp2_nxt, pmin_nxt;

  assign pm2 = in_tdata[0*WORD_W +: WORD_W];
  assign pm1 = in_tdata[1*WORD_W +: WORD_W];
  assign pp1 = in_tdata[2*WORD_W +: WORD_W];
  assign pp2 = in_tdata[3*WORD_W +: WORD_W];
  assign vm1 = in_tdata[4*WORD_W +: WORD_W];
  assign vp1 = in_tdata[5*WORD_W +: WORD_W];

  always_comb begin
    dp1_neg  = pp1 < pm1;
    dp2_neg  = pp2 < pm2;
    adp1_nxt = dp1_neg ? (pm1 - pp1) : (pp1 - pm1);
    adp2_nxt = dp2_neg ? (pm2 - pp2) : (pp2 - pm2);
    pmin_nxt = dp1_neg ? pp1 : pm1;
  end

  logic [WORD_W-1:0] adp1_a_r, adp2_a_r, pmin_a_r;
  logic              neg_a_r, dp2z_a_r, vconv_a_r;

  always_ff @(posedge clk) begin
    if (rdy_a && in_tvalid) begin
      adp1_a_r  <= adp1_nxt;
      adp2_a_r  <= adp2_nxt;
      pmin_a_r  <= pmin_nxt;
      neg_a_r   <= dp1_neg ^ dp2_neg;
      dp2z_a_r  <= (pp2 == pm2);
      vconv_a_r <= $signed(vm1) > $signed(vp1);
    end
  end

  // ---------------- stage B: threshold product, overflow check ----------
  logic [PROD_W-1:0] rhs_b_r;
  logic [NUM_W-1:0]  num_b_r;
  logic [WORD_W-1:0] den_b_r;
  logic              neg_b_r, dp2z_b_r, vconv_b_r, ovf_b_r;
  logic [NUM_W-1:0]  num_a;

  assign num_a = {adp1_a_r, {FRAC_W{1'b0}}};

  always_ff @(posedge clk) begin
    if (rdy_b && va_r) begin
      rhs_b_r   <= shock_eps_r * pmin_a_r;
      num_b_r   <= num_a;
      den_b_r   <= adp2_a_r;
      neg_b_r   <= neg_a_r;
      dp2z_b_r  <= dp2z_a_r;
      vconv_b_r <= vconv_a_r;
      // quotient of 2^32 or more saturates whatever the sign
      ovf_b_r   <= PROD_W'(num_a) >= {adp2_a_r, {QBITS{1'b0}}};
    end
  end

  // ---------------- stage S: shock decision ----------------
  logic [NUM_W-1:0]  num_s_r;
  logic [WORD_W-1:0] den_s_r;
  psf_side_t         side_s_r;

  always_ff @(posedge clk) begin
    if (rdy_s && vb_r) begin
      num_s_r           <= num_b_r;
      den_s_r           <= den_b_r;
      side_s_r.shock    <= (PROD_W'(num_b_r) > rhs_b_r) && vconv_b_r;
      side_s_r.neg      <= neg_b_r;
      side_s_r.dp2_zero <= dp2z_b_r;
      side_s_r.ovf      <= ovf_b_r;
    end
  end

  // ---------------- ratio magnitude divider ----------------
  logic [QBITS-1:0] div_quo;
  psf_side_t        div_side;

  psf_div u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (vs_r),
    .in_ready  (div_in_ready),
    .in_num    (num_s_r),
    .in_den    (den_s_r),
    .in_side   (side_s_r),
    .out_valid (div_out_valid),
    .out_ready (rdy_c),
    .out_quo   (div_quo),
    .out_side  (div_side)
  );

  // ---------------- stage C: signed, saturated ratio ----------------
  logic [WORD_W-1:0] ratio_nxt, ratio_c_r;
  logic              shock_c_r;

  always_comb begin
    if (div_side.dp2_zero) begin
      ratio_nxt = RATIO_ONE;
    end else if (div_side.ovf) begin
      ratio_nxt = div_side.neg ? RATIO_MIN : RATIO_MAX;
    end else if (!div_side.neg) begin
      ratio_nxt = div_quo[QBITS-1] ? RATIO_MAX : div_quo;
    end else begin
      ratio_nxt = (div_quo > RATIO_MIN) ? RATIO_MIN : (~div_quo + 1'b1);
    end
  end

  always_ff @(posedge clk) begin
    if (rdy_c && div_out_valid) begin
      ratio_c_r <= ratio_nxt;
      shock_c_r <= div_side.shock;
    end
  end

  // ---------------- stage D: subtract offset ----------------
  logic [DIFF_W-1:0] diff;
  logic [WORD_W-2:0] diff_d_r;
  logic              live_d_r;

  assign diff = {{2{ratio_c_r[WORD_W-1]}}, ratio_c_r} - {2'b00, omega_one_r};

  always_ff @(posedge clk) begin
    if (rdy_d && vc_r) begin
      diff_d_r <= diff[WORD_W-2:0];
      live_d_r <= shock_c_r && !diff[DIFF_W-1] && (diff != '0);
    end
  end

  // ---------------- stage E: scale ----------------
  logic [PROD_W-2:0] prod_e_r;
  logic              live_e_r;

  always_ff @(posedge clk) begin
    if (rdy_e && vd_r) begin
      prod_e_r <= diff_d_r * omega_two_r;
      live_e_r <= live_d_r;
    end
  end

  // ---------------- stage F: floor to Q.16, clamp, output register -------
  logic [PROD_W-2-FRAC_W:0] q_e;
  logic [FT_W-1:0]          ftilde_nxt, ftilde_r;

  assign q_e = prod_e_r[PROD_W-2:FRAC_W];

  always_comb begin
    if (!live_e_r) begin
      ftilde_nxt = '0;
    end else if (q_e > (PROD_W-1-FRAC_W)'(ONE_Q16)) begin
      ftilde_nxt = ONE_Q16;
    end else begin
      ftilde_nxt = q_e[FT_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rdy_f && ve_r) begin
      ftilde_r <= ftilde_nxt;
    end
  end

  assign out_tvalid = vf_r;
  assign out_tdata  = {{(OUT_W-FT_W){1'b0}}, ftilde_r};

  // ---------------- assertions ----------------
  a_ftilde_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[FT_W-1:0] <= ONE_Q16))
    else $error("ftilde above one");

  a_ready_pass: assert property (@(posedge clk) disable iff (!rst_n)
    out_tready |-> in_tready)
    else $error("input stalled while output drains");

  a_ratio_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (vc_r && !rdy_d) |=> (vc_r && $stable(ratio_c_r)))
    else $error("stalled ratio stage changed");

endmodule
